// ===== hw/rtl/mpq_pkg.sv =====
`timescale 1ns / 1ps

package mpq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	// request codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// result codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [VAL_W-1:0] item_data;
		logic signed [VAL_W-1:0] item_priority;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] removed_data;
		logic signed [VAL_W-1:0] removed_priority;
		logic [CNT_W-1:0]        occupancy;
	} out_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] prio;
		logic signed [VAL_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic             en;
		logic             first;
		logic [IDX_W-1:0] idx;
	} best_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_SETUP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FINISH
	} state_t;

endpackage

// ===== hw/rtl/mpq_mem.sv =====
`timescale 1ns / 1ps

module mpq_mem
	import mpq_pkg::*;
(
	input  logic             clk,
	input  mem_wr_t          wr,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/mpq_best.sv =====
`timescale 1ns / 1ps

module mpq_best
	import mpq_pkg::*;
(
	input  logic             clk,
	input  best_ctl_t        ctl,
	input  entry_t           entry,
	output entry_t           best,
	output logic [IDX_W-1:0] best_idx
);

	entry_t           best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             take;

	// later entries win ties, hence less-or-equal
	assign take = ctl.first || ($signed(entry.prio) <= $signed(best_q.prio));

	always_ff @(posedge clk) begin
		if (ctl.en && take) begin
			best_q     <= entry;
			best_idx_q <= ctl.idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

// ===== hw/rtl/min_priority_queue_unit.sv =====
`timescale 1ns / 1ps

// Priority queue of DEPTH entries (data and signed priority) held in insertion
// order in a single-port-read, single-port-write memory. One item is worked on
// at a time; in_stall is high from acceptance until its result is loaded into
// the output register, which can still be waiting on out_stall while the next
// item is accepted. Insert, clear and the unused mode go from ST_EXEC straight
// to ST_FINISH. Remove with entries held scans them all: the minimum search
// reads one entry a cycle through the memory's read port into one shared
// comparator, and closing the gap moves one entry at a time (read, then write
// back). Remove on an empty queue goes straight from ST_EXEC to ST_FINISH. The
// memory needs no clearing after reset: only entries below the fill count are
// ever read.
module min_priority_queue_unit
	import mpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [VAL_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
	logic [IDX_W-1:0] sh_idx_q, sh_idx_d;
	logic [VAL_W-1:0] head_prio_q;
	in_item_t         req_q;
	out_item_t        res_q, res_d;
	out_item_t        out_next;
	logic             out_valid_q;
	out_item_t        out_item_q;
	logic             load_out;

	mem_wr_t          mem_wr;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	best_ctl_t        best_ctl;
	entry_t           best;
	logic [IDX_W-1:0] best_idx;

	mpq_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared comparator, keeps the running minimum
	mpq_best u_best (
		.clk      (clk),
		.ctl      (best_ctl),
		.entry    (rd_data),
		.best     (best),
		.best_idx (best_idx)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			head_prio_q <= {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_wr_en) begin
				head_prio_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_idx_q <= cmp_idx_d;
		sh_idx_q  <= sh_idx_d;
		res_q     <= res_d;
		if (in_valid && !in_stall) begin
			req_q <= in_item;
		end
		if (load_out) begin
			out_item_q <= out_next;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		cmp_idx_d = cmp_idx_q;
		sh_idx_d  = sh_idx_q;
		res_d     = res_q;
		mem_wr    = '0;
		rd_addr   = '0;
		best_ctl  = '0;
		load_out  = 1'b0;
		// result with the fill level after this item
		out_next           = res_q;
		out_next.occupancy = count_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_d   = '0;
				state_d = ST_FINISH;
				unique case (req_q.mode)
					MODE_INSERT: begin
						if (count_q == CNT_W'(DEPTH)) begin
							res_d.status = STAT_FULL;
						end else begin
							mem_wr.en        = 1'b1;
							mem_wr.addr      = count_q[IDX_W-1:0];
							mem_wr.data.data = req_q.item_data;
							// first entry takes the configured head priority
							mem_wr.data.prio = (count_q == '0) ? head_prio_q
								: req_q.item_priority;
							count_d = count_q + CNT_W'(1);
						end
					end
					MODE_REMOVE: begin
						if (count_q == '0) begin
							res_d.status = STAT_EMPTY;
						end else begin
							rd_addr   = '0;
							cmp_idx_d = '0;
							state_d   = ST_SCAN;
						end
					end
					MODE_CLEAR: begin
						count_d = '0;
					end
					default: begin
						// unused mode, nothing changes
					end
				endcase
			end
			ST_SCAN: begin
				// rd_data holds the entry at cmp_idx_q
				best_ctl.en    = 1'b1;
				best_ctl.first = (cmp_idx_q == '0);
				best_ctl.idx   = cmp_idx_q;
				if ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q) begin
					state_d = ST_SETUP;
				end else begin
					rd_addr   = cmp_idx_q + IDX_W'(1);
					cmp_idx_d = cmp_idx_q + IDX_W'(1);
				end
			end
			ST_SETUP: begin
				res_d.removed_data     = best.data;
				res_d.removed_priority = best.prio;
				sh_idx_d               = best_idx;
				state_d                = ST_SHIFT_RD;
			end
			ST_SHIFT_RD: begin
				// close the gap one entry at a time
				if ((CNT_W'(sh_idx_q) + CNT_W'(1)) < count_q) begin
					rd_addr = sh_idx_q + IDX_W'(1);
					state_d = ST_SHIFT_WR;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = ST_FINISH;
				end
			end
			ST_SHIFT_WR: begin
				mem_wr.en   = 1'b1;
				mem_wr.addr = sh_idx_q;
				mem_wr.data = rd_data;
				sh_idx_d    = sh_idx_q + IDX_W'(1);
				state_d     = ST_SHIFT_RD;
			end
			ST_FINISH: begin
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/mpq_checker.sv =====
`timescale 1ns / 1ps

module mpq_checker
	import mpq_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input out_item_t        out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// an accepted item keeps the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a second item back to back");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.occupancy <= CNT_W'(DEPTH))
		else $error("occupancy beyond depth");

	// error results carry zero payload and match the fill level
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STAT_FULL |->
			out_item.occupancy == CNT_W'(DEPTH) && out_item.removed_data == '0
			&& out_item.removed_priority == '0)
		else $error("bad full result");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STAT_EMPTY |->
			out_item.occupancy == '0 && out_item.removed_data == '0
			&& out_item.removed_priority == '0)
		else $error("bad empty result");

endmodule

bind min_priority_queue_unit mpq_checker u_mpq_checker (.*);
